// ===== design/mptt_pkg.sv =====
`timescale 1ns / 1ps

package mptt_pkg;

	// frame layout
	localparam int SYNC_BYTES      = 6;
	localparam int ADDRESS_REPEATS = 16;
	localparam int MAC_LEN         = 6;
	localparam int FRAME_LEN       = SYNC_BYTES + MAC_LEN * ADDRESS_REPEATS;

	typedef logic [6:0] pos_t;
	typedef logic [2:0] mac_idx_t;
	typedef logic [3:0] run_t;
	typedef logic [1:0] cfg_idx_t;

	localparam pos_t     POS_MAX      = 7'd127;
	localparam pos_t     POS_SYNC_END = pos_t'(SYNC_BYTES);
	localparam pos_t     POS_FRAME    = pos_t'(FRAME_LEN);
	localparam pos_t     POS_LAST     = pos_t'(FRAME_LEN - 1);
	localparam mac_idx_t MAC_IDX_LAST = mac_idx_t'(MAC_LEN - 1);
	localparam run_t     RUN_MAX      = 4'd15;
	localparam logic [7:0] SYNC_CODE  = 8'hFF;

	// register reset values
	localparam logic [47:0] TARGET_MAC_RESET = 48'd0;
	localparam logic [7:0]  WINDOW_RESET     = 8'd3;
	localparam run_t        TRIGGER_RESET    = 4'd3;

	// register indexes
	localparam cfg_idx_t CFG_TARGET_MAC = 2'd0;
	localparam cfg_idx_t CFG_WINDOW     = 2'd1;
	localparam cfg_idx_t CFG_TRIGGER    = 2'd2;

endpackage

// ===== design/magic_packet_triple_trigger.sv =====
`timescale 1ns / 1ps
// result: registered when its end-of-packet byte leaves the input register
// throughput: one byte per cycle unless a final byte waits for a stalled result slot;
//   the rate is set by the single compare and position update per byte
// reset (arst_n low, asynchronous): registers return to their defaults, run count,
//   position and last valid time clear, no result pending

module magic_packet_triple_trigger (
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_packet,
	input  logic [31:0] now_seconds,
	// result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic        packet_ok,
	output logic [3:0]  run_count,
	output logic        shutdown_request,
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	// configuration registers
	logic [47:0]       target_mac_q;
	logic [7:0]        window_q;
	mptt_pkg::run_t    trigger_q;

	// input register
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              eop_s1;
	logic [31:0]       now_s1;

	// packet state
	mptt_pkg::pos_t     pos_q;
	mptt_pkg::mac_idx_t mac_idx_q;
	logic               still_q;
	mptt_pkg::run_t     run_q;
	logic [31:0]        last_time_q;

	// result register
	logic              out_valid_q;
	logic              ok_q;
	mptt_pkg::run_t    count_q;
	logic              fire_q;

	logic              in_xfer;
	logic              out_free;
	logic              adv;
	logic [7:0]        exp_byte;
	logic              byte_ok;
	logic              ok_next;
	logic [31:0]       gap;
	logic              in_window;
	mptt_pkg::run_t    run_next;
	logic              fire_next;

	assign cfg_ready = 1'b1;

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_mac_q <= mptt_pkg::TARGET_MAC_RESET;
			window_q     <= mptt_pkg::WINDOW_RESET;
			trigger_q    <= mptt_pkg::TRIGGER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mptt_pkg::CFG_TARGET_MAC: target_mac_q <= cfg_data;
				mptt_pkg::CFG_WINDOW:     window_q     <= cfg_data[7:0];
				mptt_pkg::CFG_TRIGGER:    trigger_q    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// handshake: non-final bytes always move on, final bytes need a free result slot
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && (!eop_s1 || out_free);
	assign in_stall = valid_s1 && !adv;
	assign in_xfer  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= data_byte;
			eop_s1  <= end_of_packet;
			now_s1  <= now_seconds;
		end
	end

	// expected address byte, first wire byte in the top bits
	always_comb begin
		case (mac_idx_q)
			3'd0:    exp_byte = target_mac_q[47:40];
			3'd1:    exp_byte = target_mac_q[39:32];
			3'd2:    exp_byte = target_mac_q[31:24];
			3'd3:    exp_byte = target_mac_q[23:16];
			3'd4:    exp_byte = target_mac_q[15:8];
			3'd5:    exp_byte = target_mac_q[7:0];
			default: exp_byte = target_mac_q[7:0];
		endcase
	end

	// byte check against sync run, address repeats, or overlong
	always_comb begin
		if (pos_q < mptt_pkg::POS_SYNC_END) begin
			byte_ok = (byte_s1 == mptt_pkg::SYNC_CODE);
		end else if (pos_q >= mptt_pkg::POS_FRAME) begin
			byte_ok = 1'b0;
		end else begin
			byte_ok = (byte_s1 == exp_byte);
		end
	end

	assign ok_next   = still_q && byte_ok && (pos_q == mptt_pkg::POS_LAST);
	assign gap       = now_s1 - last_time_q;
	assign in_window = (gap <= {24'd0, window_q});

	// run update for a finished packet
	always_comb begin
		run_next  = run_q;
		fire_next = 1'b0;
		if (!ok_next) begin
			run_next = 4'd0;
		end else if (!in_window) begin
			run_next  = 4'd1;
			fire_next = (trigger_q == 4'd1);
		end else if (run_q < mptt_pkg::RUN_MAX) begin
			run_next  = run_q + 4'd1;
			fire_next = ((run_q + 4'd1) == trigger_q);
		end
	end

	// packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			mac_idx_q   <= '0;
			still_q     <= 1'b1;
			run_q       <= '0;
			last_time_q <= '0;
		end else if (adv) begin
			if (eop_s1) begin
				pos_q     <= '0;
				mac_idx_q <= '0;
				still_q   <= 1'b1;
				run_q     <= run_next;
				if (ok_next) begin
					last_time_q <= now_s1;
				end
			end else begin
				if (pos_q < mptt_pkg::POS_MAX) begin
					pos_q <= pos_q + 7'd1;
				end
				if (pos_q >= mptt_pkg::POS_SYNC_END) begin
					mac_idx_q <= (mac_idx_q == mptt_pkg::MAC_IDX_LAST) ? 3'd0
						: mac_idx_q + 3'd1;
				end
				still_q <= still_q && byte_ok;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && eop_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && eop_s1) begin
			ok_q    <= ok_next;
			count_q <= run_next;
			fire_q  <= fire_next;
		end
	end

	assign out_valid        = out_valid_q;
	assign packet_ok        = ok_q;
	assign run_count        = count_q;
	assign shutdown_request = fire_q;

	// a shutdown request only comes with a valid packet
	a_fire_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!fire_q || ok_q))
		else $error("shutdown request on an invalid packet");

	// valid packet leaves a nonzero run, invalid one clears it
	a_count_matches_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (ok_q == (count_q != 4'd0)))
		else $error("run count disagrees with packet status");

	// packet state restarts after a final byte
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && eop_s1) |=> (pos_q == 7'd0 && still_q && mac_idx_q == 3'd0))
		else $error("packet state not restarted after final byte");

	// a final byte never overwrites the result while the result slot is stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !(adv && eop_s1))
		else $error("result overwritten while stalled");

endmodule

// ===== tb/tb_magic_packet_triple_trigger.sv =====
`timescale 1ns / 1ps

module tb_magic_packet_triple_trigger;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [7:0]  data;
		logic        eop;
		logic [31:0] stamp;
	} rx_byte_t;

	typedef struct packed {
		logic           ok;
		mptt_pkg::run_t run;
		logic           fire;
	} wol_report_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         data_byte = '0;
	logic               end_of_packet = 1'b0;
	logic [31:0]        now_seconds = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               packet_ok;
	mptt_pkg::run_t     run_count;
	logic               shutdown_request;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	mptt_pkg::cfg_idx_t cfg_index = '0;
	logic [47:0]        cfg_data = '0;

	rx_byte_t    rx_bytes_q[$];
	wol_report_t expected_reports_q[$];

	// detector mirror: registers and per-packet state
	logic [47:0]    mac_cfg = mptt_pkg::TARGET_MAC_RESET;
	logic [7:0]     window_cfg = mptt_pkg::WINDOW_RESET;
	mptt_pkg::run_t trigger_cfg = mptt_pkg::TRIGGER_RESET;
	mptt_pkg::pos_t trk_pos = '0;
	logic           trk_match = 1'b1;
	mptt_pkg::run_t trk_run = '0;
	logic [31:0]    trk_last = '0;

	// packet builder view of the registers
	logic [47:0] stim_mac = mptt_pkg::TARGET_MAC_RESET;
	logic [7:0]  stim_win = mptt_pkg::WINDOW_RESET;
	logic [31:0] stim_clock = '0;

	logic in_taken = 1'b0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   hold_left = 0;
	bit   hold_arm = 1'b0;
	bit   hold_done = 1'b0;
	int   quiet_cycles = 0;
	int   err_count = 0;
	int   n_bytes = 0;
	int   n_packets = 0;
	int   n_results = 0;
	int   n_magic = 0;
	int   n_shutdown = 0;
	int   n_writes = 0;

	magic_packet_triple_trigger i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.data_byte        (data_byte),
		.end_of_packet    (end_of_packet),
		.now_seconds      (now_seconds),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.packet_ok        (packet_ok),
		.run_count        (run_count),
		.shutdown_request (shutdown_request),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #4 clk = ~clk;

	// expected report for one accepted byte
	function automatic void detect_byte(logic [7:0] b, logic eop, logic [31:0] stamp);
		logic        hit;
		logic [7:0]  length;
		logic [31:0] gap;
		int          k;
		wol_report_t rep;
		if (trk_pos < mptt_pkg::POS_SYNC_END) begin
			hit = (b == mptt_pkg::SYNC_CODE);
		end else if (trk_pos >= mptt_pkg::POS_FRAME) begin
			hit = 1'b0;
		end else begin
			k = (int'(trk_pos) - mptt_pkg::SYNC_BYTES) % mptt_pkg::MAC_LEN;
			hit = (b == mac_cfg[47 - 8 * k -: 8]);
		end
		if (!hit)
			trk_match = 1'b0;
		length = {1'b0, trk_pos} + 8'd1;
		if (trk_pos < mptt_pkg::POS_MAX)
			trk_pos++;
		if (!eop)
			return;
		rep.ok = trk_match && (length == 8'(mptt_pkg::FRAME_LEN));
		rep.fire = 1'b0;
		trk_pos = '0;
		trk_match = 1'b1;
		if (rep.ok) begin
			gap = stamp - trk_last;
			if (gap <= 32'(window_cfg)) begin
				if (trk_run < mptt_pkg::RUN_MAX) begin
					trk_run++;
					rep.fire = (trk_run == trigger_cfg);
				end
			end else begin
				trk_run = 4'd1;
				rep.fire = (trigger_cfg == 4'd1);
			end
			trk_last = stamp;
		end else begin
			trk_run = '0;
		end
		rep.run = trk_run;
		expected_reports_q.push_back(rep);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (err_count < 50)
			$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		err_count++;
	endtask

	// one datagram: sync run, repeated address, then anything past the frame; an optional corrupted byte, or all noise
	task automatic add_packet(int len, int bad_pos, bit noise, logic [31:0] stamp);
		logic [7:0] v;
		for (int i = 0; i < len; i++) begin
			if (noise || i >= mptt_pkg::FRAME_LEN)
				v = 8'($urandom);
			else if (i < mptt_pkg::SYNC_BYTES)
				v = mptt_pkg::SYNC_CODE;
			else
				v = stim_mac[47 - 8 * ((i - mptt_pkg::SYNC_BYTES) % mptt_pkg::MAC_LEN) -: 8];
			if (i == bad_pos)
				v ^= 8'($urandom_range(1, 255));
			rx_bytes_q.push_back('{v, i == len - 1, (i == len - 1) ? stamp : 32'($urandom)});
			n_bytes++;
		end
		n_packets++;
	endtask

	// timestamp for the next packet, mostly within or just past the window
	function automatic logic [31:0] next_time();
		int          r;
		logic [31:0] gap;
		r = $urandom_range(0, 99);
		if (r < 45)
			gap = $urandom_range(0, stim_win);
		else if (r < 60)
			gap = 32'(stim_win);
		else if (r < 75)
			gap = 32'(stim_win) + 1;
		else if (r < 90)
			gap = $urandom_range(0, 300);
		else
			gap = $urandom;
		stim_clock = stim_clock + gap;
		return stim_clock;
	endfunction

	task automatic random_packets(int min_bytes, int min_pkts);
		int start_bytes;
		int pkts;
		int r;
		start_bytes = n_bytes;
		pkts = 0;
		while (n_bytes - start_bytes < min_bytes || pkts < min_pkts) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				add_packet(mptt_pkg::FRAME_LEN, -1, 1'b0, next_time());
			else if (r < 67)
				add_packet(mptt_pkg::FRAME_LEN, $urandom_range(0, mptt_pkg::FRAME_LEN - 1),
					1'b0, next_time());
			else if (r < 77)
				add_packet($urandom_range(1, mptt_pkg::FRAME_LEN - 1), -1, 1'b0, next_time());
			else if (r < 87)
				add_packet($urandom_range(mptt_pkg::FRAME_LEN + 1, 140), -1, 1'b0,
					next_time());
			else
				add_packet($urandom_range(1, 8), -1, 1'b1, next_time());
			pkts++;
		end
	endtask

	task automatic write_reg(mptt_pkg::cfg_idx_t idx, logic [47:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			mptt_pkg::CFG_TARGET_MAC: stim_mac = value;
			mptt_pkg::CFG_WINDOW:     stim_win = value[7:0];
			default: ;
		endcase
	endtask

	// all bytes sent and every report back, then let the pipeline settle
	task automatic wait_drained();
		do @(posedge clk); while (rx_bytes_q.size() != 0 || in_valid ||
			expected_reports_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// byte driver
	always @(negedge clk) begin
		rx_byte_t nxt;
		if (arst_n && (!in_valid || in_taken)) begin
			if (rx_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = rx_bytes_q.pop_front();
				in_valid      <= 1'b1;
				data_byte     <= nxt.data;
				end_of_packet <= nxt.eop;
				now_seconds   <= nxt.stamp;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// report sink with random stalls and one long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_arm && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// monitor: register writes, byte transfers, report checks, watchdog
	always @(posedge clk) begin
		wol_report_t want;
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mptt_pkg::CFG_TARGET_MAC: mac_cfg = cfg_data;
					mptt_pkg::CFG_WINDOW:     window_cfg = cfg_data[7:0];
					mptt_pkg::CFG_TRIGGER:    trigger_cfg = cfg_data[3:0];
					default: ;
				endcase
				n_writes++;
			end
			if (in_valid && !in_stall)
				detect_byte(data_byte, end_of_packet, now_seconds);
			if (out_valid && !out_stall) begin
				n_results++;
				if (expected_reports_q.size() == 0) begin
					report_mismatch("report with none pending, packet_ok", int'(packet_ok), 0);
				end else begin
					want = expected_reports_q.pop_front();
					n_magic += int'(want.ok);
					n_shutdown += int'(want.fire);
					if (packet_ok !== want.ok)
						report_mismatch("packet_ok", int'(packet_ok), int'(want.ok));
					if (run_count !== want.run)
						report_mismatch("run_count", int'(run_count), int'(want.run));
					if (shutdown_request !== want.fire)
						report_mismatch("shutdown_request", int'(shutdown_request),
							int'(want.fire));
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no transfer for %0d cycles", QUIET_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] t;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset registers: zero address, window 3, trigger 3
		// run restarts, crosses the clock wrap, fires at three and saturates at fifteen
		send_idle_pct = 29;
		recv_idle_pct = 59;
		t = 32'hFFFF_FFF0;
		for (int i = 0; i < 16; i++) begin
			add_packet(mptt_pkg::FRAME_LEN, -1, 1'b0, t);
			t += 32'd3;
		end
		add_packet(140, -1, 1'b0, t);
		stim_clock = t;
		wait_drained();

		// all-ones address, zero window, trigger on every restart
		send_idle_pct = 59;
		recv_idle_pct = 29;
		write_reg(mptt_pkg::CFG_TARGET_MAC, 48'hFFFF_FFFF_FFFF);
		write_reg(mptt_pkg::CFG_WINDOW, 48'd0);
		write_reg(mptt_pkg::CFG_TRIGGER, 48'd1);
		random_packets(150, 2);
		wait_drained();

		// trigger zero never requests shutdown
		write_reg(mptt_pkg::CFG_TARGET_MAC, 48'd0);
		write_reg(mptt_pkg::CFG_WINDOW, 48'($urandom_range(0, 255)));
		write_reg(mptt_pkg::CFG_TRIGGER, 48'd0);
		random_packets(150, 2);
		wait_drained();

		// no idling, with one long hold-off on the report side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(mptt_pkg::CFG_TARGET_MAC, 48'({$urandom, $urandom}));
		write_reg(mptt_pkg::CFG_WINDOW, 48'd2);
		write_reg(mptt_pkg::CFG_TRIGGER, 48'd2);
		random_packets(200, 3);
		hold_arm = 1'b1;
		wait_drained();

		$display("sent %0d bytes in %0d packets with %0d register writes", n_bytes, n_packets,
			n_writes);
		$display("checked %0d reports: %0d magic packets, %0d shutdown requests",
			n_results, n_magic, n_shutdown);
		if (err_count == 0 && expected_reports_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
